>>> design/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types, constants and helpers for the scaled 3x3 box stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int MAX_COLS      = 1024;
  localparam int MAX_ROWS      = 1024;
  localparam int COL_BITS      = $clog2(MAX_COLS);
  localparam int ROW_BITS      = $clog2(MAX_ROWS);
  localparam int GEOM_BITS     = 11;
  localparam int COEF_BITS     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Three samples per window column, nine per window.
  localparam int COL_SUM_BITS  = SAMPLE_BITS + 2;
  localparam int SUM_BITS      = SAMPLE_BITS + 4;
  localparam int PROD_BITS     = SUM_BITS + COEF_BITS + 1;
  localparam int ROUND_SHIFT   = COEF_BITS;
  localparam int SCALED_BITS   = PROD_BITS - ROUND_SHIFT;

  localparam logic [COEF_BITS-1:0] COEF_RESET = COEF_BITS'(7282);
  localparam logic [GEOM_BITS-1:0] GEOM_MIN   = GEOM_BITS'(3);
  localparam logic [GEOM_BITS-1:0] COLS_MAX   = GEOM_BITS'(MAX_COLS);
  localparam logic [GEOM_BITS-1:0] ROWS_MAX   = GEOM_BITS'(MAX_ROWS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_COLS   = 2'd0,
    REG_GRID_ROWS   = 2'd1,
    REG_COEFFICIENT = 2'd2
  } reg_idx_e;

  // Clamps a geometry value to 3..hi and returns the index of the last row or column.
  function automatic logic [COL_BITS-1:0] geom_last(input logic [GEOM_BITS-1:0] v,
                                                     input logic [GEOM_BITS-1:0] hi);
    logic [GEOM_BITS-1:0] c;
    begin
      if (v < GEOM_MIN) begin
        c = GEOM_MIN;
      end else if (v > hi) begin
        c = hi;
      end else begin
        c = v;
      end
      geom_last = COL_BITS'(c - GEOM_BITS'(1));
    end
  endfunction

endpackage

`default_nettype wire

>>> design/box_stencil_3x3_scaled.sv
// ----------------------------------------------------------------------------
// box_stencil_3x3_scaled
// Nine-point box stencil over a raster grid stream, scaled and saturated.
// ----------------------------------------------------------------------------
// Usage:
//   The whole grid, halo included, enters on the s_axis channel in raster
//   order, one signed Q8.16 sample per transfer. For every interior point one
//   transfer leaves on m_axis carrying the rounded, saturated product of the
//   coefficient and the nine-point sum; tlast marks the final interior point.
//   Halo samples that complete no interior point produce no output.
//   m_axis_tvalid rises once the sample that completes its window has passed
//   the stage 1, stage 2, stage 3 and output registers, and one sample is
//   taken every cycle while m_axis keeps up. The two previous rows live in one
//   1024 x 48 synchronous memory, read when a sample is taken and written
//   back when that sample leaves the first stage; each entry is reused
//   only a full row later, so no forwarding is needed.
//   Reset sets the geometry to 1024 x 1024 and the coefficient to 7282 and
//   empties the pipeline; the memory needs no clearing pass. Writing either
//   geometry register restarts at row 0, column 0. Registers must be written
//   only while idle; the block does not enforce this. When m_axis stalls, the
//   stages fill up and s_axis_tready drops only once each holds a result.
// ----------------------------------------------------------------------------
`default_nettype none

module box_stencil_3x3_scaled
  import bss_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire  [CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire  [CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire  [SAMPLE_BITS-1:0]    s_axis_tdata,   // [23:0] sample
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [SAMPLE_BITS-1:0]    m_axis_tdata,   // [23:0] result
  output logic                      m_axis_tlast    // is_last
);

  localparam logic signed [SCALED_BITS-1:0] SAT_MAX =
    SCALED_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SCALED_BITS-1:0] SAT_MIN =
    SCALED_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [PROD_BITS-1:0] ROUND_BIAS =
    PROD_BITS'(64'sd1 <<< (ROUND_SHIFT - 1));

  // Configuration
  logic [COL_BITS-1:0]  cols_last_q;
  logic [COL_BITS-1:0]  rows_last_q;
  logic [COEF_BITS-1:0] coef_q;
  logic                 restart;

  // Position of the next sample
  logic [COL_BITS-1:0]  col_q;
  logic [ROW_BITS-1:0]  row_q;

  // Stage 1: line memory read
  logic                     s1_v_q, s1_res_q, s1_last_q;
  logic [COL_BITS-1:0]      s1_col_q;
  logic [SAMPLE_BITS-1:0]   s1_sample_q;
  logic [2*SAMPLE_BITS-1:0] rd_q;
  logic [SAMPLE_BITS-1:0]   s1_top, s1_mid;

  // Window held as two column sums
  logic signed [COL_SUM_BITS-1:0] cs0_q, cs1_q, cs_new;
  logic signed [SUM_BITS-1:0]     sum_d;

  // Stage 2: sum, stage 3: product, then output register
  logic                        s2_v_q, s2_last_q;
  logic signed [SUM_BITS-1:0]  s2_sum_q;
  logic                        s3_v_q, s3_last_q;
  logic signed [PROD_BITS-1:0] s3_prod_q;
  logic signed [PROD_BITS-1:0] rounded;
  logic signed [SCALED_BITS-1:0] scaled;
  logic [SAMPLE_BITS-1:0]      result_d;
  logic                        out_v_q;

  logic [2*SAMPLE_BITS-1:0] line_mem [MAX_COLS];

  logic out_free, s3_free, s2_free, s1_free, accept, s1_leave;

  assign out_free = !out_v_q || m_axis_tready;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_free  = !s1_v_q || !s1_res_q || s2_free;
  assign s_axis_tready = s1_free;
  assign accept   = s_axis_tvalid && s1_free;
  assign s1_leave = s1_v_q && s1_free;

  assign restart = cfg_we_i && ((cfg_idx_i == REG_GRID_COLS) || (cfg_idx_i == REG_GRID_ROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_last_q <= COL_BITS'(MAX_COLS - 1);
      rows_last_q <= ROW_BITS'(MAX_ROWS - 1);
      coef_q      <= COEF_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_GRID_COLS:   cols_last_q <= geom_last(cfg_data_i[GEOM_BITS-1:0], COLS_MAX);
        REG_GRID_ROWS:   rows_last_q <= geom_last(cfg_data_i[GEOM_BITS-1:0], ROWS_MAX);
        REG_COEFFICIENT: coef_q      <= cfg_data_i[COEF_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // Raster position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == cols_last_q) begin
        col_q <= '0;
        row_q <= (row_q == rows_last_q) ? '0 : row_q + ROW_BITS'(1);
      end else begin
        col_q <= col_q + COL_BITS'(1);
      end
    end
  end

  // Each entry holds {row r-2, row r-1} for one column.
  always_ff @(posedge clk_i) begin
    if (s1_leave) begin
      line_mem[s1_col_q] <= {s1_mid, s1_sample_q};
    end
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
  end

  assign s1_top = rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign s1_mid = rd_q[SAMPLE_BITS-1:0];

  assign cs_new = COL_SUM_BITS'(signed'(s1_top)) + COL_SUM_BITS'(signed'(s1_mid))
                + COL_SUM_BITS'(signed'(s1_sample_q));
  assign sum_d  = SUM_BITS'(cs0_q) + SUM_BITS'(cs1_q) + SUM_BITS'(cs_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      cs0_q   <= '0;
      cs1_q   <= '0;
    end else begin
      if (s1_free) s1_v_q  <= accept;
      if (s2_free) s2_v_q  <= s1_v_q && s1_res_q;
      if (s3_free) s3_v_q  <= s2_v_q;
      if (out_free) out_v_q <= s3_v_q;
      if (restart) begin
        cs0_q <= '0;
        cs1_q <= '0;
      end else if (s1_leave) begin
        cs0_q <= cs1_q;
        cs1_q <= cs_new;
      end
    end
  end

  assign rounded = s3_prod_q + ROUND_BIAS;
  assign scaled  = SCALED_BITS'(rounded >>> ROUND_SHIFT);

  always_comb begin
    if (scaled > SAT_MAX) begin
      result_d = SAMPLE_BITS'(SAT_MAX);
    end else if (scaled < SAT_MIN) begin
      result_d = SAMPLE_BITS'(SAT_MIN);
    end else begin
      result_d = scaled[SAMPLE_BITS-1:0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= s_axis_tdata;
      s1_col_q    <= col_q;
      s1_res_q    <= (row_q >= ROW_BITS'(2)) && (col_q >= COL_BITS'(2));
      s1_last_q   <= (row_q == rows_last_q) && (col_q == cols_last_q);
    end
    if (s2_free && s1_v_q && s1_res_q) begin
      s2_sum_q  <= sum_d;
      s2_last_q <= s1_last_q;
    end
    if (s3_free && s2_v_q) begin
      s3_prod_q <= s2_sum_q * signed'({1'b0, coef_q});
      s3_last_q <= s2_last_q;
    end
    if (out_free && s3_v_q) begin
      m_axis_tdata <= result_d;
      m_axis_tlast <= s3_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;

endmodule

`default_nettype wire

>>> design/bss_checker.sv
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks for the scaled 3x3 box stencil.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_checker
  import bss_pkg::*;
(
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     s_axis_tvalid,
  input wire                     s_axis_tready,
  input wire                     m_axis_tvalid,
  input wire                     m_axis_tready,
  input wire [SAMPLE_BITS-1:0]   m_axis_tdata,   // [23:0] result
  input wire                     m_axis_tlast    // is_last
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // With the output side free, the input side never pushes back.
  a_no_idle_stall: assert property (@(posedge clk_i)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output side is free");

  // A result on an empty output comes from a sample taken earlier at the input.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 4))
    else $error("result without a matching input transfer");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind box_stencil_3x3_scaled bss_checker u_bss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
